// ===== hw/rtl/nrbh_pkg.sv =====
// Package for the nearest ray-box hit block: widths, register indexes,
// beat types and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package nrbh_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_BOXES_DEF   = 1024;
  localparam int COORD_W         = 32;
  localparam int DIR_W           = 18;
  localparam int DIST_W          = 31;
  localparam int SIZE_W          = 24;
  localparam int HIT_INDEX_W     = 10;
  localparam int BOUND_W         = 33;
  localparam int NUM_W           = 34;
  localparam int DVD_W           = NUM_W + FRAC_BITS;
  localparam int QUOT_W          = 35;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int AXES            = 3;

  localparam logic [QUOT_W-1:0] QSAT = (QUOT_W'(1) << 33) - QUOT_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MERGE,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     dir_zero;
    logic                     contained;
    logic signed [QUOT_W-1:0] qa;
    logic signed [QUOT_W-1:0] qb;
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      has_type;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
    logic                      entity_dead;
    logic                      last_entity;
  } in_item_t;

  typedef struct packed {
    logic                      hit_found;
    logic [HIT_INDEX_W-1:0]    hit_index;
    logic [DIST_W-1:0]         hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic                      overflow;
  } out_item_t;

endpackage

// ===== hw/rtl/nrbh_div_lane.sv =====
// One slab quotient lane: restoring divider, one quotient bit a cycle,
// truncating toward zero and saturating. Depends on nrbh_pkg.
`timescale 1ns / 1ps

module nrbh_div_lane import nrbh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DIR_W-1:0]  den,
  output logic                     done,
  output logic signed [QUOT_W-1:0] quot
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DIR_W-1:0]  dvs;
  logic [DIR_W-1:0]  rem;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] steps;

  logic [NUM_W-1:0]  num_mag;
  logic [DIR_W-1:0]  den_mag;
  logic [DIR_W:0]    trial;
  logic [DIR_W:0]    diff;
  logic              fits;
  logic [QUOT_W-1:0] qmag;

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_mag = den[DIR_W-1] ? DIR_W'(-den) : DIR_W'(den);
    trial   = {rem, dvd[DVD_W-1]};
    fits    = trial >= {1'b0, dvs};
    diff    = trial - {1'b0, dvs};
    qmag    = (dvd > DVD_W'(QSAT)) ? QSAT : QUOT_W'(dvd);
    quot    = neg ? QUOT_W'(-$signed(qmag)) : $signed(qmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && steps == STEP_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= DVD_W'(num_mag) << FRAC_BITS;
      dvs   <= den_mag;
      rem   <= '0;
      neg   <= num[NUM_W-1] ^ den[DIR_W-1];
      steps <= STEP_W'(DVD_W);
    end else if (busy) begin
      rem   <= fits ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
      dvd   <= {dvd[DVD_W-2:0], fits};
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

// ===== hw/rtl/nrbh_merge.sv =====
// Merging stage: combines the three axis lanes into entry/exit distances
// and a registered hit decision. Depends on nrbh_pkg.
`timescale 1ns / 1ps

module nrbh_merge import nrbh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  axis_t             ax [AXES],
  input  logic [DIST_W-1:0] best,
  output logic              hit,
  output logic [DIST_W-1:0] t0
);

  logic signed [QUOT_W-1:0] t0_c;
  logic signed [QUOT_W-1:0] t1_c;
  logic signed [QUOT_W-1:0] lo_t;
  logic signed [QUOT_W-1:0] hi_t;
  logic                     ok;

  always_comb begin
    t0_c = '0;
    t1_c = '0;
    t1_c[DIST_W-1:0] = best;
    lo_t = '0;
    hi_t = '0;
    ok   = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (ax[a].dir_zero) begin
        if (!ax[a].contained) ok = 1'b0;
      end else begin
        lo_t = (ax[a].qa > ax[a].qb) ? ax[a].qb : ax[a].qa;
        hi_t = (ax[a].qa > ax[a].qb) ? ax[a].qa : ax[a].qb;
        if (lo_t > t0_c) t0_c = lo_t;
        if (hi_t < t1_c) t1_c = hi_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (en) begin
      hit <= ok && (t0_c <= t1_c);
    end
  end

  // t0 lies in [0, best] whenever hit is set
  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= t0_c[DIST_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/nrbh_point_lane.sv =====
// Hit point for one axis: registered dir * t, floor shift, add origin,
// saturate to 32 bits. Depends on nrbh_pkg.
`timescale 1ns / 1ps

module nrbh_point_lane import nrbh_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DIST_W-1:0]         t,
  input  logic signed [DIR_W-1:0]   dir,
  input  logic signed [COORD_W-1:0] origin,
  output logic signed [COORD_W-1:0] point
);

  localparam int PROD_W = DIR_W + DIST_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dir * $signed({1'b0, t});
    end
  end

  always_comb begin
    sum = SUM_W'(prod >>> FRAC_BITS) + SUM_W'(origin);
    if (sum > SMAX)      point = SMAX[COORD_W-1:0];
    else if (sum < SMIN) point = SMIN[COORD_W-1:0];
    else                 point = sum[COORD_W-1:0];
  end

endmodule

// ===== hw/rtl/nearest_ray_box_hit.sv =====
// Top level of the nearest ray-box hit block: config registers, sequencer,
// six divider lanes, merge stage and hit point lanes. Depends on nrbh_pkg.
`timescale 1ns / 1ps

// Channel   Signals                               Beat
// item      item_valid, item_stall, item          one entity box
// result    result_valid, result_stall, result    one query result
// cfg       cfg_valid, cfg_ready, cfg_index/data  one register write
//
// A live box runs through the six divider lanes, each retiring one quotient
// bit a cycle on Q16.16 values, then merge, multiply and update; a dead box or
// one beyond capacity goes straight to the update. No new box is taken until one is through.
// rst is synchronous; it clears registers and the running query.
// The result sits in an output register; the next query's boxes are taken
// while it waits, and only a further last box holds on a stalled result.

module nearest_ray_box_hit import nrbh_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // configuration
  logic signed [COORD_W-1:0] origin [AXES];
  logic signed [DIR_W-1:0]   dir    [AXES];
  logic [DIST_W-1:0]         max_distance;

  // running query state
  logic [DIST_W-1:0]         best_dist;
  logic [CNT_W-1:0]          best_slot;
  logic                      any_hit;
  logic [CNT_W-1:0]          box_count;
  logic                      count_overflow;
  logic signed [COORD_W-1:0] best_h [AXES];

  // per item
  state_t            state;
  state_t            state_next;
  logic              last_q;
  logic              skip_q;
  logic [CNT_W-1:0]  slot_q;
  logic              dir_zero_q  [AXES];
  logic              contained_q [AXES];

  logic              accept;
  logic              over;
  logic              skip;
  logic              done_go;
  logic              take;

  logic signed [SIZE_W:0]    hw;
  logic signed [SIZE_W:0]    hh;
  logic signed [BOUND_W-1:0] lo     [AXES];
  logic signed [BOUND_W-1:0] hi     [AXES];
  logic signed [BOUND_W-1:0] o_ext  [AXES];
  logic signed [NUM_W-1:0]   num_lo [AXES];
  logic signed [NUM_W-1:0]   num_hi [AXES];
  logic signed [QUOT_W-1:0]  q_lo   [AXES];
  logic signed [QUOT_W-1:0]  q_hi   [AXES];
  logic [2*AXES-1:0]         lane_done;
  axis_t                     ax     [AXES];
  logic                      m_hit;
  logic [DIST_W-1:0]         m_t0;
  logic signed [COORD_W-1:0] pt     [AXES];

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign over       = (box_count >= CNT_W'(MAX_BOXES));
  assign skip       = item.entity_dead || over;
  assign done_go    = (state == S_DONE) && !(last_q && result_valid && result_stall);
  assign take       = !skip_q && m_hit;

  // box bounds; y runs up from the foot, x and z are centred
  always_comb begin
    hw = item.has_type ? $signed({2'b00, item.box_width[SIZE_W-1:1]})
                       : ((SIZE_W+1)'(1) <<< (FRAC_BITS - 1));
    hh = item.has_type ? $signed({1'b0, item.box_height})
                       : ((SIZE_W+1)'(1) <<< FRAC_BITS);
    lo[0] = BOUND_W'(item.pos_x) - BOUND_W'(hw);
    hi[0] = BOUND_W'(item.pos_x) + BOUND_W'(hw);
    lo[1] = BOUND_W'(item.pos_y);
    hi[1] = BOUND_W'(item.pos_y) + BOUND_W'(hh);
    lo[2] = BOUND_W'(item.pos_z) - BOUND_W'(hw);
    hi[2] = BOUND_W'(item.pos_z) + BOUND_W'(hw);
    for (int a = 0; a < AXES; a++) begin
      o_ext[a]  = BOUND_W'(origin[a]);
      num_lo[a] = NUM_W'(lo[a]) - NUM_W'(origin[a]);
      num_hi[a] = NUM_W'(hi[a]) - NUM_W'(origin[a]);
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    nrbh_div_lane u_lo (
      .clk   (clk),
      .rst   (rst),
      .start (accept && !skip),
      .num   (num_lo[a]),
      .den   (dir[a]),
      .done  (lane_done[2*a]),
      .quot  (q_lo[a])
    );
    nrbh_div_lane u_hi (
      .clk   (clk),
      .rst   (rst),
      .start (accept && !skip),
      .num   (num_hi[a]),
      .den   (dir[a]),
      .done  (lane_done[2*a+1]),
      .quot  (q_hi[a])
    );
    nrbh_point_lane u_pt (
      .clk    (clk),
      .en     (state == S_MUL),
      .t      (m_t0),
      .dir    (dir[a]),
      .origin (origin[a]),
      .point  (pt[a])
    );
    assign ax[a] = '{dir_zero: dir_zero_q[a], contained: contained_q[a],
                     qa: q_lo[a], qb: q_hi[a]};
  end

  nrbh_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .en   (state == S_MERGE),
    .ax   (ax),
    .best (best_dist),
    .hit  (m_hit),
    .t0   (m_t0)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        origin[a] <= '0;
        dir[a]    <= '0;
      end
      max_distance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0]    <= cfg_data;
        REG_ORIGIN_Y: origin[1]    <= cfg_data;
        REG_ORIGIN_Z: origin[2]    <= cfg_data;
        REG_DIR_X:    dir[0]       <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dir[1]       <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:    dir[2]       <= cfg_data[DIR_W-1:0];
        REG_MAX_DIST: max_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = skip ? S_DONE : S_DIV;
      S_DIV:   if (&lane_done) state_next = S_MERGE;
      S_MERGE: state_next = S_MUL;
      S_MUL:   state_next = S_DONE;
      S_DONE:  if (done_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // per-item latches
  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= item.last_entity;
      skip_q <= skip;
      slot_q <= box_count;
      for (int a = 0; a < AXES; a++) begin
        dir_zero_q[a]  <= (dir[a] == '0);
        contained_q[a] <= !(o_ext[a] < lo[a] || o_ext[a] > hi[a]);
      end
    end
  end

  // running query state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist      <= '0;
      best_slot      <= '0;
      any_hit        <= 1'b0;
      box_count      <= '0;
      count_overflow <= 1'b0;
      result_valid   <= 1'b0;
      for (int a = 0; a < AXES; a++) best_h[a] <= '0;
    end else begin
      if (result_valid && !result_stall && !(done_go && last_q)) result_valid <= 1'b0;
      if (accept) begin
        // first box of a query loads the distance limit
        if (box_count == '0 && !count_overflow) best_dist <= max_distance;
        if (over) count_overflow <= 1'b1;
        else      box_count      <= box_count + CNT_W'(1);
      end
      if (done_go) begin
        if (last_q) begin
          result_valid        <= 1'b1;
          result.hit_found    <= any_hit || take;
          result.hit_index    <= take ? HIT_INDEX_W'(slot_q)
                               : (any_hit ? HIT_INDEX_W'(best_slot) : '0);
          result.hit_distance <= take ? m_t0 : (any_hit ? best_dist : '0);
          result.hit_x        <= take ? pt[0] : (any_hit ? best_h[0] : '0);
          result.hit_y        <= take ? pt[1] : (any_hit ? best_h[1] : '0);
          result.hit_z        <= take ? pt[2] : (any_hit ? best_h[2] : '0);
          result.overflow     <= count_overflow;
          best_dist      <= max_distance;
          best_slot      <= '0;
          any_hit        <= 1'b0;
          box_count      <= '0;
          count_overflow <= 1'b0;
          for (int a = 0; a < AXES; a++) best_h[a] <= '0;
        end else if (take) begin
          best_dist <= m_t0;
          best_slot <= slot_q;
          any_hit   <= 1'b1;
          for (int a = 0; a < AXES; a++) best_h[a] <= pt[a];
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_slot_seen: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> best_slot < box_count)
    else $error("kept slot not yet counted");

  a_lanes_even: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (lane_done == '0 || lane_done == '1))
    else $error("divider lanes out of step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted box left sequencer idle");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for nearest_ray_box_hit: directed and random box streams under
// several ray settings, checked against a scoreboard class. Depends on nrbh_pkg.
`timescale 1ns / 1ps

module tb_top import nrbh_pkg::*; ();

  localparam int CAPACITY = MAX_BOXES_DEF;
  localparam int SETTLE   = 100;
  localparam int ITEM_W   = $bits(in_item_t);

  // Scoreboard: keeps its own copy of the ray and the running query, works out
  // the result due on each last box and checks result beats against it.
  class HitBoard;
    longint org [3];
    longint dir [3];
    longint max_dist;
    longint nearest;
    int     nearest_slot;
    bit     found;
    int     boxes_seen;
    bit     overran;
    longint pt [3];
    out_item_t due_results[$];
    int     errors;

    function new();
      for (int a = 0; a < 3; a++) begin
        org[a] = 0; dir[a] = 0; pt[a] = 0;
      end
      max_dist = 0; nearest = 0; nearest_slot = 0; found = 0;
      boxes_seen = 0; overran = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ORIGIN_X: org[0] = longint'(signed'(d));
        REG_ORIGIN_Y: org[1] = longint'(signed'(d));
        REG_ORIGIN_Z: org[2] = longint'(signed'(d));
        REG_DIR_X:    dir[0] = longint'(signed'(d[DIR_W-1:0]));
        REG_DIR_Y:    dir[1] = longint'(signed'(d[DIR_W-1:0]));
        REG_DIR_Z:    dir[2] = longint'(signed'(d[DIR_W-1:0]));
        REG_MAX_DIST: max_dist = longint'({1'b0, d[DIST_W-1:0]});
        default: ;
      endcase
    endfunction

    function longint sat_quot(longint num, longint d);
      longint q;
      longint lim;
      lim = (longint'(1) << 33) - 1;
      q = (num * (longint'(1) << FRAC_BITS)) / d;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return q;
    endfunction

    // one axis of the slab test; narrows [t0, t1] and says if it is still open
    function bit slab_axis(longint o, longint d, longint lo, longint hi,
                           ref longint t0, ref longint t1);
      longint ta;
      longint tb;
      longint x;
      if (d == 0) return !(o < lo || o > hi);
      ta = sat_quot(lo - o, d);
      tb = sat_quot(hi - o, d);
      if (ta > tb) begin x = ta; ta = tb; tb = x; end
      if (ta > t0) t0 = ta;
      if (tb < t1) t1 = tb;
      return t0 <= t1;
    endfunction

    // origin + dir * t, scaled down with floor, clamped to 32 bits
    function longint ray_point(longint o, longint d, longint t);
      longint p;
      longint s;
      longint r;
      p = d * t;
      s = p >>> FRAC_BITS;
      r = o + s;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function void note_box(in_item_t it);
      longint hw;
      longint hh;
      longint t0;
      longint t1;
      longint pos [3];
      out_item_t r;
      pos[0] = longint'(it.pos_x);
      pos[1] = longint'(it.pos_y);
      pos[2] = longint'(it.pos_z);
      if (boxes_seen == 0 && !overran) nearest = max_dist;
      if (boxes_seen >= CAPACITY) begin
        overran = 1;
      end else begin
        if (!it.entity_dead) begin
          hw = it.has_type ? longint'(it.box_width >> 1) : (longint'(1) << (FRAC_BITS - 1));
          hh = it.has_type ? longint'(it.box_height) : (longint'(1) << FRAC_BITS);
          t0 = 0;
          t1 = nearest;
          if (slab_axis(org[0], dir[0], pos[0] - hw, pos[0] + hw, t0, t1) &&
              slab_axis(org[1], dir[1], pos[1], pos[1] + hh, t0, t1) &&
              slab_axis(org[2], dir[2], pos[2] - hw, pos[2] + hw, t0, t1)) begin
            nearest = t0;
            nearest_slot = boxes_seen;
            found = 1;
            for (int a = 0; a < 3; a++) pt[a] = ray_point(org[a], dir[a], t0);
          end
        end
        boxes_seen++;
      end
      if (!it.last_entity) return;
      r = '0;
      if (found) begin
        r.hit_found    = 1'b1;
        r.hit_index    = nearest_slot[HIT_INDEX_W-1:0];
        r.hit_distance = nearest[DIST_W-1:0];
        r.hit_x        = pt[0][COORD_W-1:0];
        r.hit_y        = pt[1][COORD_W-1:0];
        r.hit_z        = pt[2][COORD_W-1:0];
      end
      r.overflow = overran;
      due_results = {due_results, r};
      nearest = max_dist; nearest_slot = 0; found = 0; boxes_seen = 0; overran = 0;
      for (int a = 0; a < 3; a++) pt[a] = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report("unexpected result beat", got.hit_index, 0);
        return;
      end
      want = due_results.pop_front();
      if (got.hit_found    !== want.hit_found)    report("hit_found", got.hit_found, want.hit_found);
      if (got.hit_index    !== want.hit_index)    report("hit_index", got.hit_index, want.hit_index);
      if (got.hit_distance !== want.hit_distance)
        report("hit_distance", got.hit_distance, want.hit_distance);
      if (got.hit_x        !== want.hit_x)        report("hit_x", got.hit_x, want.hit_x);
      if (got.hit_y        !== want.hit_y)        report("hit_y", got.hit_y, want.hit_y);
      if (got.hit_z        !== want.hit_z)        report("hit_z", got.hit_z, want.hit_z);
      if (got.overflow     !== want.overflow)     report("overflow", got.overflow, want.overflow);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  in_item_t              item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  HitBoard board = new();
  bit      no_idle = 1'b0;   // quiet stretch: neither side idles
  bit      hold_req = 1'b0;  // ask the result side for a long hold-off
  int      hold_left = 0;

  nearest_ray_box_hit uut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check each accepted beat, stall at random or hold off.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) board.check_result(result);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        result_stall <= 1'b1;
      end else begin
        result_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 31);
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Offer one box; an idle gap goes before it at random.
  task send_box(in_item_t it);
    if (!no_idle && $urandom_range(99) < 31) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    board.note_box(it);
  endtask

  // Sender pause: drop valid and wait for every due result, then settle.
  task drain();
    item_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
               int dx, int dy, int dz, logic [30:0] md);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, 32'(dx));
    write_reg(REG_DIR_Y, 32'(dy));
    write_reg(REG_DIR_Z, 32'(dz));
    write_reg(REG_MAX_DIST, {1'b0, md});
  endtask

  function automatic in_item_t mk_box(longint x, longint y, longint z, bit typed,
                                      int w, int h, bit dead, bit last);
    in_item_t it;
    it.pos_x = x[31:0]; it.pos_y = y[31:0]; it.pos_z = z[31:0];
    it.has_type = typed;
    it.box_width = w[23:0]; it.box_height = h[23:0];
    it.entity_dead = dead; it.last_entity = last;
    return it;
  endfunction

  // Random box: mostly placed on the ray at a random distance with jitter,
  // otherwise fully random noise.
  function automatic in_item_t rand_box(bit last);
    in_item_t it;
    longint t;
    longint c [3];
    int jit;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.last_entity = last;
    it.entity_dead = ($urandom_range(9) == 0);
    if ($urandom_range(9) < 7) begin
      t = longint'($urandom_range(0, 32'h0040_0000));
      jit = $urandom_range(0, 32'h0002_0000);
      for (int a = 0; a < 3; a++)
        c[a] = board.org[a] + ((board.dir[a] * t) >>> FRAC_BITS)
               + longint'($urandom_range(0, jit)) - jit / 2;
      c[1] = c[1] - 64'sh8000;
      it.pos_x = c[0][31:0];
      it.pos_y = c[1][31:0];
      it.pos_z = c[2][31:0];
      if ($urandom_range(3) != 0) begin
        it.box_width  = 24'($urandom_range(0, 32'h0004_0000));
        it.box_height = 24'($urandom_range(0, 32'h0004_0000));
      end
    end
    return it;
  endfunction

  function automatic int rand_dir();
    if ($urandom_range(5) == 0) return 0;
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  task random_queries(int n);
    int left;
    int qlen;
    left = n;
    while (left > 0) begin
      qlen = $urandom_range(1, 8);
      for (int i = 0; i < qlen; i++) send_box(rand_box(i == qlen - 1));
      left -= qlen;
    end
  endtask

  initial begin
    int qs;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ray along +x from the origin, limit at the top of the range.
    set_ray(32'h0, 32'h0, 32'h0, 65536, 0, 0, 31'h7FFF_FFFF);
    send_box(mk_box(0, -32'sh8000, 0, 0, 0, 0, 0, 1));              // origin inside
    send_box(mk_box(32'sh0005_0000, -32'sh8000, 0, 0, 0, 0, 0, 0));
    send_box(mk_box(32'sh0003_0000, -32'sh8000, 0, 1, 32'h2_0000, 32'h1_0000, 0, 0));
    send_box(mk_box(32'sh0003_0000, -32'sh8000, 0, 0, 0, 0, 1, 1)); // dead, nearer one kept
    send_box(mk_box(32'sh0004_0000, -32'sh8000, 0, 0, 0, 0, 0, 0)); // tie: later wins
    send_box(mk_box(32'sh0004_0000, -32'sh8000, 0, 0, 0, 0, 0, 1));
    send_box(mk_box(0, 32'sh0005_0000, 0, 0, 0, 0, 0, 1));          // zero-dir axis miss
    send_box(mk_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                    24'hFF_FFFF, 24'hFF_FFFF, 0, 0));
    send_box(mk_box(-32'sh8000_0000, -32'sh1, -32'sh8000_0000, 1,
                    24'hFF_FFFF, 24'hFF_FFFF, 0, 1));
    drain();

    // Negative unit direction on every axis, origin far out, zero distance limit.
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -65536, -65536, -65536, 31'h0);
    send_box(mk_box(-32'sh8000_0000, 32'h7FFF_0000, -32'sh8000_0000, 1,
                    24'hFF_FFFF, 24'h1_0000, 0, 0));
    send_box(mk_box(0, 0, 0, 1, 0, 0, 0, 1));
    drain();
    set_ray(32'h0, 32'h0, 32'h0, 0, 0, 0, 31'h10_0000);
    send_box(mk_box(0, 0, 0, 0, 0, 0, 0, 0));
    send_box(mk_box(0, -32'sh10_0000, 0, 1, 24'h1, 24'h1, 0, 1));
    drain();

    // Random phases under several ray settings.
    for (int ph = 0; ph < 5; ph++) begin
      set_ray($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
              $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
              (ph == 4) ? $urandom : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
              rand_dir(), rand_dir(), rand_dir(),
              (ph == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 32'h0080_0000)));
      if (ph == 1) no_idle = 1'b1;
      random_queries(80);
      no_idle = 1'b0;
      if (ph == 2) begin
        // long hold-off on results while short queries keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_box(rand_box(1));
      end
      if (ph == 3) drain();
      random_queries(80);
      drain();
    end

    item_valid <= 1'b0;
    qs = 0;
    while (board.due_results.size() != 0 && qs < 200000) begin
      @(posedge clk);
      qs++;
    end
    repeat (SETTLE) @(posedge clk);
    if (board.due_results.size() != 0)
      board.report("results still due", board.due_results.size(), 0);
    if (board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nrbh_pkg.sv
hw/rtl/nrbh_div_lane.sv
hw/rtl/nrbh_merge.sv
hw/rtl/nrbh_point_lane.sv
hw/rtl/nearest_ray_box_hit.sv
verif/tb_top.sv
